### hw/rtl/bgrd_pkg.sv
package bgrd_pkg;

    localparam int unsigned RecLen = 27;
    localparam int unsigned PosW   = 5;

    typedef struct packed {
        logic [27:0] latitude;
        logic [34:0] longitude;
        logic [21:0] altitude;
        logic [14:0] course;
        logic [20:0] speed;
        logic [30:0] date_packed;
        logic [23:0] time_packed;
        logic [5:0]  valid_flags;
        logic        fix_valid;
        logic [47:0] locator;
    } t_result;

    typedef struct packed {
        logic        ok;
        logic [7:0]  lat_deg;
        logic [7:0]  lat_min;
        logic [7:0]  lat_m100;
        logic [7:0]  lat_m10k;
        logic        lat_pos;
        logic [7:0]  lon_d100;
        logic [7:0]  lon_deg;
        logic [7:0]  lon_min;
        logic [7:0]  lon_m100;
        logic [7:0]  lon_m10k;
        logic        lon_pos;
        logic [7:0]  alt_k;
        logic [7:0]  alt_t;
        logic [7:0]  alt_d;
        logic        alt_neg;
        logic        alt_ok;
        logic [7:0]  crs_h;
        logic [7:0]  crs_l;
        logic [7:0]  spd_k;
        logic [7:0]  spd_t;
        logic [7:0]  spd_d;
        logic        spd_ok;
        logic [7:0]  yr_h;
        logic [7:0]  yr_l;
        logic [7:0]  mon;
        logic [7:0]  day;
        logic [7:0]  hr;
        logic [7:0]  mnt;
        logic [7:0]  sec;
    } t_rec;

    function automatic logic [7:0] bcd(input logic [7:0] b);
        return 8'({4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]});
    endfunction

endpackage

### hw/rtl/bgrd_front.sv
module bgrd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_rec_vld,
    output bgrd_pkg::t_rec    o_rec
);

    logic [bgrd_pkg::PosW-1:0] r_pos;
    logic                      r_over;
    logic [7:0]                r_store [bgrd_pkg::RecLen-1];
    logic                      r_vld;
    bgrd_pkg::t_rec            r_rec;
    logic [7:0]                s [bgrd_pkg::RecLen];
    logic                      ok_len;

    always_comb begin
        for (int k = 0; k < int'(bgrd_pkg::RecLen) - 1; k++) s[k] = r_store[k];
        s[bgrd_pkg::RecLen-1] = i_data_byte;
        ok_len = (r_pos == bgrd_pkg::PosW'(bgrd_pkg::RecLen - 1)) && !r_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_over <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= i_push && i_last_byte;
            if (i_push) begin
                if (i_last_byte) begin
                    r_pos  <= '0;
                    r_over <= 1'b0;
                end else if (r_pos < bgrd_pkg::PosW'(bgrd_pkg::RecLen)) begin
                    r_pos <= r_pos + 1'b1;
                end else begin
                    r_over <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && r_pos < bgrd_pkg::PosW'(bgrd_pkg::RecLen - 1))
            r_store[r_pos] <= i_data_byte;
        if (i_push && i_last_byte) begin
            r_rec.ok       <= ok_len;
            r_rec.lat_deg  <= bgrd_pkg::bcd(s[0]);
            r_rec.lat_min  <= bgrd_pkg::bcd(s[1]);
            r_rec.lat_m100 <= bgrd_pkg::bcd(s[2]);
            r_rec.lat_m10k <= bgrd_pkg::bcd(s[3]);
            r_rec.lat_pos  <= s[4] == 8'd1;
            r_rec.lon_d100 <= bgrd_pkg::bcd(s[5]);
            r_rec.lon_deg  <= bgrd_pkg::bcd(s[6]);
            r_rec.lon_min  <= bgrd_pkg::bcd(s[7]);
            r_rec.lon_m100 <= bgrd_pkg::bcd(s[8]);
            r_rec.lon_m10k <= bgrd_pkg::bcd(s[9]);
            r_rec.lon_pos  <= s[10] == 8'd1;
            r_rec.alt_k    <= bgrd_pkg::bcd(s[11]);
            r_rec.alt_t    <= bgrd_pkg::bcd(s[12]);
            r_rec.alt_d    <= bgrd_pkg::bcd(s[13]);
            r_rec.alt_neg  <= s[14] == 8'd1;
            r_rec.alt_ok   <= !(&{s[11], s[12], s[13], s[14]});
            r_rec.crs_h    <= bgrd_pkg::bcd(s[15]);
            r_rec.crs_l    <= bgrd_pkg::bcd(s[16]);
            r_rec.spd_k    <= bgrd_pkg::bcd(s[17]);
            r_rec.spd_t    <= bgrd_pkg::bcd(s[18]);
            r_rec.spd_d    <= bgrd_pkg::bcd(s[19]);
            r_rec.spd_ok   <= !(&{s[17], s[18], s[19]});
            r_rec.yr_h     <= bgrd_pkg::bcd(s[20]);
            r_rec.yr_l     <= bgrd_pkg::bcd(s[21]);
            r_rec.mon      <= bgrd_pkg::bcd(s[22]);
            r_rec.day      <= bgrd_pkg::bcd(s[23]);
            r_rec.hr       <= bgrd_pkg::bcd(s[24]);
            r_rec.mnt      <= bgrd_pkg::bcd(s[25]);
            r_rec.sec      <= bgrd_pkg::bcd(s[26]);
        end
    end

    assign o_rec_vld = r_vld;
    assign o_rec     = r_rec;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= bgrd_pkg::PosW'(bgrd_pkg::RecLen)) else $error("position overrun");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && i_last_byte |=> r_pos == '0 && !r_over) else $error("no restart");
    a_vld_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_vld |-> $past(i_push && i_last_byte)) else $error("stray record");

endmodule

### hw/rtl/bgrd_back.sv
module bgrd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_vld,
    input  bgrd_pkg::t_rec    i_rec,
    output logic              o_out_vld,
    output bgrd_pkg::t_result o_res
);

    localparam logic [34:0] UDeg = 35'd600000;

    // stage 1: magnitudes
    logic        r1_vld;
    logic        r1_ok, r1_latp, r1_lonp, r1_altn, r1_alto, r1_spdo, r1_tok;
    logic [27:0] r1_lat;
    logic [34:0] r1_lon;
    logic [21:0] r1_alt;
    logic [14:0] r1_crs;
    logic [20:0] r1_spd;
    logic [30:0] r1_date;
    logic [23:0] r1_time;

    logic [14:0] year;
    logic [4:0]  dim;
    logic        leap;

    always_comb begin
        year = 15'(i_rec.yr_h * 15'd100) + 15'(i_rec.yr_l);
        leap = (i_rec.yr_l[1:0] == 2'd0)
            && ((i_rec.yr_l != 8'd0 && i_rec.yr_l != 8'd100)
                || (i_rec.yr_l == 8'd0 && i_rec.yr_h[1:0] == 2'd0)
                || (i_rec.yr_l == 8'd100 && i_rec.yr_h[1:0] == 2'd3));
        unique case (i_rec.mon)
            8'd2:                        dim = leap ? 5'd29 : 5'd28;
            8'd4, 8'd6, 8'd9, 8'd11:     dim = 5'd30;
            default:                     dim = 5'd31;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= i_in_vld;
        r1_ok   <= i_rec.ok;
        r1_latp <= i_rec.lat_pos;
        r1_lonp <= i_rec.lon_pos;
        r1_altn <= i_rec.alt_neg;
        r1_alto <= i_rec.alt_ok;
        r1_spdo <= i_rec.spd_ok;
        r1_lat  <= 28'(i_rec.lat_deg * 28'd600000) + 28'(i_rec.lat_min * 28'd10000)
                 + 28'(i_rec.lat_m100 * 28'd100) + 28'(i_rec.lat_m10k);
        r1_lon  <= 35'((i_rec.lon_d100 * 35'd100 + 35'(i_rec.lon_deg)) * UDeg)
                 + 35'(i_rec.lon_min * 35'd10000) + 35'(i_rec.lon_m100 * 35'd100)
                 + 35'(i_rec.lon_m10k);
        r1_alt  <= 22'(i_rec.alt_k * 22'd10000) + 22'(i_rec.alt_t * 22'd100)
                 + 22'(i_rec.alt_d);
        r1_crs  <= 15'(i_rec.crs_h * 15'd100) + 15'(i_rec.crs_l);
        r1_spd  <= 21'(i_rec.spd_k * 21'd10000) + 21'(i_rec.spd_t * 21'd100)
                 + 21'(i_rec.spd_d);
        r1_tok  <= year != '0 && i_rec.mon >= 8'd1 && i_rec.mon <= 8'd12
                 && i_rec.day >= 8'd1 && i_rec.day <= {3'd0, dim}
                 && i_rec.hr < 8'd24 && i_rec.mnt < 8'd60 && i_rec.sec < 8'd60;
        r1_date <= {year[14:0], i_rec.mon, i_rec.day};
        r1_time <= {i_rec.hr, i_rec.mnt, i_rec.sec};
    end

    // stage 2: signed values and shifted grid coordinates
    logic        r2_vld;
    logic        r2_ok, r2_altn, r2_alto, r2_spdo, r2_tok, r2_inr;
    logic [27:0] r2_lat;
    logic [34:0] r2_lon;
    logic [21:0] r2_alt;
    logic [14:0] r2_crs;
    logic [20:0] r2_spd;
    logic [30:0] r2_date;
    logic [23:0] r2_time;
    logic [27:0] r2_a;
    logic [27:0] r2_l;

    logic signed [28:0] la;
    logic signed [35:0] lo;

    always_comb begin
        la = (r1_latp ? $signed({1'b0, r1_lat}) : -$signed({1'b0, r1_lat}))
           + 29'sd54000000;
        lo = (r1_lonp ? $signed({1'b0, r1_lon}) : -$signed({1'b0, r1_lon}))
           + 36'sd108000000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
        r2_ok   <= r1_ok;
        r2_altn <= r1_altn;
        r2_alto <= r1_alto;
        r2_spdo <= r1_spdo;
        r2_tok  <= r1_tok;
        r2_lat  <= r1_latp ? r1_lat : 28'(-r1_lat);
        r2_lon  <= r1_lonp ? r1_lon : 35'(-r1_lon);
        r2_alt  <= r1_altn ? 22'(-r1_alt) : r1_alt;
        r2_crs  <= r1_crs;
        r2_spd  <= r1_spd;
        r2_date <= r1_date;
        r2_time <= r1_time;
        r2_inr  <= la >= 0 && la < 29'sd108000000 && lo >= 0 && lo < 36'sd216000000;
        r2_a    <= 28'(la);
        r2_l    <= 28'(lo);
    end

    // stage 3: locator field and square (small quotient searches)
    logic        r3_vld;
    bgrd_pkg::t_result r3_res;
    logic [4:0]  r3_lf;
    logic [4:0]  r3_af;
    logic [3:0]  r3_ls;
    logic [3:0]  r3_as;
    logic [20:0] r3_lr;
    logic [19:0] r3_ar;

    logic [4:0]  lq;
    logic [4:0]  aq;
    logic [27:0] lrem;
    logic [27:0] arem;
    logic [3:0]  lsq;
    logic [3:0]  asq;

    always_comb begin
        lq = '0;
        aq = '0;
        for (int k = 1; k < 18; k++) begin
            if (r2_l >= 28'(k * 12000000)) lq = 5'(k);
            if (r2_a >= 28'(k * 6000000))  aq = 5'(k);
        end
        lrem = r2_l - 28'(lq * 28'd12000000);
        arem = r2_a - 28'(aq * 28'd6000000);
        lsq = '0;
        asq = '0;
        for (int k = 1; k < 10; k++) begin
            if (lrem >= 28'(k * 1200000)) lsq = 4'(k);
            if (arem >= 28'(k * 600000))  asq = 4'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
        r3_res.latitude    <= r2_ok ? r2_lat : '0;
        r3_res.longitude   <= r2_ok ? r2_lon : '0;
        r3_res.altitude    <= (r2_ok && r2_alto) ? r2_alt : '0;
        r3_res.course      <= r2_ok ? r2_crs : '0;
        r3_res.speed       <= (r2_ok && r2_spdo) ? r2_spd : '0;
        r3_res.date_packed <= (r2_ok && r2_tok) ? r2_date : '0;
        r3_res.time_packed <= (r2_ok && r2_tok) ? r2_time : '0;
        r3_res.valid_flags <= r2_ok ? {r2_tok, r2_spdo, 1'b1, r2_alto, 2'b11} : '0;
        r3_res.fix_valid   <= r2_ok && r2_tok && r2_spdo;
        r3_res.locator     <= {47'd0, r2_ok && r2_inr};
        r3_lf <= lq;
        r3_af <= aq;
        r3_ls <= lsq;
        r3_as <= asq;
        r3_lr <= 21'(lrem - 28'(lsq * 28'd1200000));
        r3_ar <= 20'(arem - 28'(asq * 28'd600000));
    end

    // stage 4: subsquare and assembly
    logic [4:0] lsub;
    logic [4:0] asub;
    bgrd_pkg::t_result n_res;

    always_comb begin
        lsub = '0;
        asub = '0;
        for (int k = 1; k < 24; k++) begin
            if (r3_lr >= 21'(k * 50000)) lsub = 5'(k);
            if (r3_ar >= 20'(k * 25000)) asub = 5'(k);
        end
        n_res = r3_res;
        n_res.locator = r3_res.locator[0]
            ? {8'(8'd65 + r3_lf), 8'(8'd65 + r3_af), 8'(8'd48 + r3_ls),
               8'(8'd48 + r3_as), 8'(8'd97 + lsub), 8'(8'd97 + asub)}
            : 48'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out_vld <= 1'b0;
        else          o_out_vld <= r3_vld;
        o_res <= n_res;
    end

    a_flags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_vld && o_res.valid_flags == '0 |-> o_res.locator == '0)
        else $error("locator without record");
    a_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_vld && o_res.fix_valid |-> o_res.valid_flags[5] && o_res.valid_flags[4])
        else $error("fix flag mismatch");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld |=> r3_vld) else $error("pipe lost");

endmodule

### hw/rtl/bgrd_queue.sv
module bgrd_queue #(
    parameter int unsigned Depth = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  bgrd_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_afull,
    output bgrd_pkg::t_result o_data
);

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    bgrd_pkg::t_result r_mem [Depth];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [AW:0]       r_cnt;
    logic              rd;

    assign o_empty = r_cnt == '0;
    assign rd      = i_pop && !o_empty;
    // reserve room for items still in flight in the back end
    assign o_afull = r_cnt >= (AW+1)'(Depth - 5);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (rd)   r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> r_cnt < (AW+1)'(Depth) || rd) else $error("queue overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(Depth)) else $error("count range");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |=> $stable(r_rp)) else $error("read while empty");

endmodule

### hw/rtl/bcd_gps_record_decoder.sv
// A result is poppable once its last byte has passed the front end's record
// register, the four back-end stages and the queue write. Throughput: one byte per
// cycle while full is low; four registered back-end stages trail the byte collector.
// full rises only while the result queue holds Depth-5 or more results.
// Reset (synchronous, active low) empties the queue and restarts byte collection.
module bcd_gps_record_decoder #(
    parameter int unsigned Depth = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [27:0] o_latitude,
    output logic [34:0] o_longitude,
    output logic [21:0] o_altitude,
    output logic [14:0] o_course,
    output logic [20:0] o_speed,
    output logic [30:0] o_date_packed,
    output logic [23:0] o_time_packed,
    output logic [5:0]  o_valid_flags,
    output logic        o_fix_valid,
    output logic [47:0] o_locator
);

    logic              acc;
    logic              rec_vld;
    bgrd_pkg::t_rec    rec;
    logic              res_vld;
    bgrd_pkg::t_result res;
    bgrd_pkg::t_result q;

    assign acc = push && !full;

    bgrd_front u_front (
        .i_clk, .i_rst_n, .i_push(acc), .i_data_byte, .i_last_byte,
        .o_rec_vld(rec_vld), .o_rec(rec)
    );

    bgrd_back u_back (
        .i_clk, .i_rst_n, .i_in_vld(rec_vld), .i_rec(rec),
        .o_out_vld(res_vld), .o_res(res)
    );

    bgrd_queue #(.Depth(Depth)) u_queue (
        .i_clk, .i_rst_n, .i_wr(res_vld), .i_data(res), .i_pop(pop),
        .o_empty(empty), .o_afull(full), .o_data(q)
    );

    assign o_latitude    = q.latitude;
    assign o_longitude   = q.longitude;
    assign o_altitude    = q.altitude;
    assign o_course      = q.course;
    assign o_speed       = q.speed;
    assign o_date_packed = q.date_packed;
    assign o_time_packed = q.time_packed;
    assign o_valid_flags = q.valid_flags;
    assign o_fix_valid   = q.fix_valid;
    assign o_locator     = q.locator;

endmodule

### tb/bcd_gps_record_decoder_tb.sv
module bcd_gps_record_decoder_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [27:0] o_latitude;
    logic [34:0] o_longitude;
    logic [21:0] o_altitude;
    logic [14:0] o_course;
    logic [20:0] o_speed;
    logic [30:0] o_date_packed;
    logic [23:0] o_time_packed;
    logic [5:0]  o_valid_flags;
    logic        o_fix_valid;
    logic [47:0] o_locator;

    bcd_gps_record_decoder u_dut (.*);

    localparam longint UnitsDeg = 600000;

    logic [8:0] pending_bytes[$];
    bgrd_pkg::t_result expected_fixes[$];
    int         fail_count = 0;
    logic       taken = 1'b0;
    logic       hold_off = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;

    int         rec_pos = 0;
    logic       rec_overlong = 1'b0;
    logic [7:0] rec_bytes[27];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned digits(input logic [7:0] b);
        return longint'(b[7:4]) * 10 + longint'(b[3:0]);
    endfunction

    function automatic bit leap_year(input longint unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint unsigned month_days(input longint unsigned y,
                                                   input longint unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            2: return leap_year(y) ? 29 : 28;
            default: return 31;
        endcase
    endfunction

    function automatic bit all_ones(input int first, input int count);
        for (int i = first; i < first + count; i++)
            if (rec_bytes[i] != 8'hFF) return 1'b0;
        return 1'b1;
    endfunction

    // Decode one accepted byte; returns 1 when it closes a record.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output bgrd_pkg::t_result fix);
        longint lat, lon, alt, la, lo, mag;
        longint unsigned yr, mo, dy, hr, mi, se, spd, flags, loc;
        bit ok;
        fix = '0;
        if (rec_pos < 27) begin
            rec_bytes[rec_pos] = b;
            rec_pos++;
        end else begin
            rec_overlong = 1'b1;
        end
        if (!last) return 1'b0;
        ok = (rec_pos == 27) && !rec_overlong;
        rec_pos = 0;
        rec_overlong = 1'b0;
        if (!ok) return 1'b1;

        mag = digits(rec_bytes[0]) * UnitsDeg + digits(rec_bytes[1]) * 10000
            + digits(rec_bytes[2]) * 100 + digits(rec_bytes[3]);
        lat = (rec_bytes[4] == 8'd1) ? mag : -mag;
        mag = (digits(rec_bytes[5]) * 100 + digits(rec_bytes[6])) * UnitsDeg
            + digits(rec_bytes[7]) * 10000 + digits(rec_bytes[8]) * 100
            + digits(rec_bytes[9]);
        lon = (rec_bytes[10] == 8'd1) ? mag : -mag;
        flags = 6'b001011;
        alt = 0;
        if (!all_ones(11, 4)) begin
            mag = digits(rec_bytes[11]) * 10000 + digits(rec_bytes[12]) * 100
                + digits(rec_bytes[13]);
            alt = (rec_bytes[14] == 8'd1) ? -mag : mag;
            flags |= 4;
        end
        spd = 0;
        if (!all_ones(17, 3)) begin
            spd = digits(rec_bytes[17]) * 10000 + digits(rec_bytes[18]) * 100
                + digits(rec_bytes[19]);
            flags |= 16;
        end
        yr = digits(rec_bytes[20]) * 100 + digits(rec_bytes[21]);
        mo = digits(rec_bytes[22]);
        dy = digits(rec_bytes[23]);
        hr = digits(rec_bytes[24]);
        mi = digits(rec_bytes[25]);
        se = digits(rec_bytes[26]);
        if (yr != 0 && mo >= 1 && mo <= 12 && dy >= 1 && dy <= month_days(yr, mo)
            && hr < 24 && mi < 60 && se < 60) begin
            fix.date_packed = 31'((yr << 16) | (mo << 8) | dy);
            fix.time_packed = 24'((hr << 16) | (mi << 8) | se);
            flags |= 32;
        end
        loc = 0;
        la = lat + 90 * UnitsDeg;
        lo = lon + 180 * UnitsDeg;
        if (la >= 0 && la < 180 * UnitsDeg && lo >= 0 && lo < 360 * UnitsDeg) begin
            loc = {8'("A" + lo / (20 * UnitsDeg)),
                   8'("A" + la / (10 * UnitsDeg)),
                   8'("0" + (lo % (20 * UnitsDeg)) / (2 * UnitsDeg)),
                   8'("0" + (la % (10 * UnitsDeg)) / UnitsDeg),
                   8'("a" + (lo % (2 * UnitsDeg)) / 50000),
                   8'("a" + (la % UnitsDeg) / 25000)};
        end
        fix.latitude    = 28'(lat);
        fix.longitude   = 35'(lon);
        fix.altitude    = 22'(alt);
        fix.course      = 15'(digits(rec_bytes[15]) * 100 + digits(rec_bytes[16]));
        fix.speed       = 21'(spd);
        fix.valid_flags = 6'(flags);
        fix.fix_valid   = ((flags & 6'h3B) == 6'h3B);
        fix.locator     = 48'(loc);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        bgrd_pkg::t_result fix;
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            taken <= push && !full;
            if (push && !full && decode_byte(i_data_byte, i_last_byte, fix))
                expected_fixes.push_back(fix);
            if (pop && !empty) begin
                if (expected_fixes.size() == 0) begin
                    $error("result popped with none expected");
                    fail_count++;
                end else begin
                    fix = expected_fixes.pop_front();
                    check_field("latitude", fix.latitude, o_latitude);
                    check_field("longitude", fix.longitude, o_longitude);
                    check_field("altitude", fix.altitude, o_altitude);
                    check_field("course", fix.course, o_course);
                    check_field("speed", fix.speed, o_speed);
                    check_field("date_packed", fix.date_packed, o_date_packed);
                    check_field("time_packed", fix.time_packed, o_time_packed);
                    check_field("valid_flags", fix.valid_flags, o_valid_flags);
                    check_field("fix_valid", fix.fix_valid, o_fix_valid);
                    check_field("locator", fix.locator, o_locator);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        logic [8:0] req;
        if (i_rst_n && (!push || taken)) begin
            if (gap_left > 0) begin
                push <= 1'b0;
                gap_left--;
            end else if (pending_bytes.size() > 0) begin
                req = pending_bytes.pop_front();
                push <= 1'b1;
                i_data_byte <= req[7:0];
                i_last_byte <= req[8];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        int phase;
        if (i_rst_n) begin
            phase = int'(($time / 20 / 97) % 4);
            if (hold_off) pop <= 1'b0;
            else if (phase == 0) pop <= 1'b1;
            else if (phase == 1) pop <= ($urandom_range(0, 3) != 0);
            else if (phase == 2) pop <= ($urandom_range(0, 3) == 0);
            else pop <= (($time / 20) % 5) != 0;
        end
    end

    function automatic logic [7:0] to_bcd(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    task automatic add_record(input logic [7:0] rec[], input int len);
        for (int i = 0; i < len; i++)
            pending_bytes.push_back({i == len - 1, rec[i % 27]});
    endtask

    task automatic add_fix(input int lat_d, input int lat_s, input int lon_d,
                           input int lon_s, input int yr, input int mo,
                           input int dy, input int hr, input int mi, input int se);
        logic [7:0] rec[];
        rec = new[27];
        rec[0] = to_bcd(lat_d);
        rec[1] = to_bcd($urandom_range(0, 59));
        rec[2] = to_bcd($urandom_range(0, 99));
        rec[3] = to_bcd($urandom_range(0, 99));
        rec[4] = 8'(lat_s);
        rec[5] = to_bcd(lon_d / 100);
        rec[6] = to_bcd(lon_d % 100);
        rec[7] = to_bcd($urandom_range(0, 59));
        rec[8] = to_bcd($urandom_range(0, 99));
        rec[9] = to_bcd($urandom_range(0, 99));
        rec[10] = 8'(lon_s);
        for (int i = 11; i < 14; i++) rec[i] = to_bcd($urandom_range(0, 99));
        rec[14] = 8'($urandom_range(0, 2));
        rec[15] = to_bcd($urandom_range(0, 3));
        rec[16] = to_bcd($urandom_range(0, 99));
        for (int i = 17; i < 20; i++) rec[i] = to_bcd($urandom_range(0, 99));
        rec[20] = to_bcd(yr / 100);
        rec[21] = to_bcd(yr % 100);
        rec[22] = to_bcd(mo);
        rec[23] = to_bcd(dy);
        rec[24] = to_bcd(hr);
        rec[25] = to_bcd(mi);
        rec[26] = to_bcd(se);
        if ($urandom_range(0, 9) == 0) for (int i = 11; i < 15; i++) rec[i] = 8'hFF;
        if ($urandom_range(0, 9) == 0) for (int i = 17; i < 20; i++) rec[i] = 8'hFF;
        add_record(rec, 27);
    endtask

    initial begin
        logic [7:0] rec[];
        int len;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        rec = new[27];

        foreach (rec[i]) rec[i] = 8'hFF;
        add_record(rec, 27);
        foreach (rec[i]) rec[i] = 8'h00;
        add_record(rec, 27);
        add_record(rec, 1);
        add_record(rec, 26);
        add_record(rec, 28);
        add_fix(12, 1, 34, 0, 2000, 2, 29, 23, 59, 59);
        add_fix(12, 0, 34, 1, 1900, 2, 29, 0, 0, 0);
        add_fix(45, 1, 179, 1, 2024, 2, 29, 12, 30, 30);
        add_fix(45, 1, 179, 1, 2023, 2, 29, 12, 30, 30);
        add_fix(5, 2, 100, 1, 0, 1, 1, 0, 0, 0);
        add_fix(5, 1, 100, 1, 2021, 13, 1, 0, 0, 0);
        add_fix(5, 1, 100, 1, 2021, 4, 31, 0, 0, 0);
        add_fix(5, 1, 100, 1, 2021, 4, 30, 24, 0, 0);
        add_fix(5, 1, 100, 1, 2021, 4, 30, 0, 60, 0);
        add_fix(5, 1, 100, 1, 2021, 4, 30, 0, 0, 60);
        add_fix(5, 1, 100, 1, 2021, 0, 0, 0, 0, 0);
        foreach (rec[i]) rec[i] = 8'h00;
        rec[0] = 8'h90;
        rec[5] = 8'h01;
        rec[6] = 8'h80;
        add_record(rec, 27);
        rec[4] = 8'd1;
        rec[10] = 8'd1;
        add_record(rec, 27);

        repeat (16) begin
            case ($urandom_range(0, 9))
                0: begin
                    foreach (rec[i]) rec[i] = 8'($urandom);
                    add_record(rec, 27);
                end
                1: begin
                    foreach (rec[i]) rec[i] = 8'($urandom);
                    len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 26)
                                                      : $urandom_range(28, 40);
                    add_record(rec, len);
                end
                default:
                    add_fix($urandom_range(0, 95), $urandom_range(0, 2),
                            $urandom_range(0, 185), $urandom_range(0, 2),
                            $urandom_range(1895, 2105), $urandom_range(1, 12),
                            $urandom_range(1, 31), $urandom_range(0, 23),
                            $urandom_range(0, 59), $urandom_range(0, 59));
            endcase
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_bytes.size() == 0 && !push);
        wait (expected_fixes.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_fixes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
hw/rtl/bgrd_pkg.sv
hw/rtl/bgrd_front.sv
hw/rtl/bgrd_back.sv
hw/rtl/bgrd_queue.sv
hw/rtl/bcd_gps_record_decoder.sv
tb/bcd_gps_record_decoder_tb.sv
